@@ src/mlsrv_pkg.sv @@
// Shared types and constants for the queued mutex lock server.
package mlsrv_pkg;

    // Default number of waiter slots
    localparam int DEF_WAIT_DEPTH = 16;

    // Field widths
    localparam int ID_W   = 8;
    localparam int WHO_W  = 2 * ID_W;
    localparam int STAT_W = 3;

    // Request kinds carried in tuser
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_HELD      = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_HANDOVER  = 3'd3,
        ST_FREED     = 3'd4,
        ST_NOTHOLDER = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    // One request: client identity is {machine_id, mailbox}
    typedef struct packed {
        logic             req_type;
        logic [WHO_W-1:0] who;
    } t_request;

    // One result: named client is {reply_machine, reply_mailbox}
    typedef struct packed {
        logic             respond;
        t_status          status;
        logic [WHO_W-1:0] who;
    } t_result;

endpackage

@@ src/mlsrv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mlsrv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/mlsrv_engine.sv @@
// Lock state, owner compare and waiter queue; decides one request per cycle while i_fire is high.
module mlsrv_engine
    import mlsrv_pkg::*;
#(
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_request i_req,
    output t_result  o_result
);

    localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WAIT_DEPTH);

    logic             r_busy, n_busy;
    logic [WHO_W-1:0] r_owner, n_owner;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_byp_valid;
    logic [WHO_W-1:0] r_byp_data;

    logic             holder;
    logic             q_full;
    logic             q_empty;
    logic             wr_en;
    logic [WHO_W-1:0] ram_rd_data;
    logic [WHO_W-1:0] head_who;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    // Waiter storage; read address follows the next head pointer
    mlsrv_ram #(
        .WIDTH (WHO_W),
        .DEPTH (WAIT_DEPTH)
    ) u_waiters (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_req.who),
        .i_rd_addr (n_head),
        .o_rd_data (ram_rd_data)
    );

    // Oldest waiter, forwarded when it was written in the cycle it was read
    assign head_who = r_byp_valid ? r_byp_data : ram_rd_data;

    // Decide the request and the next lock state
    always_comb begin
        holder   = r_busy && (r_owner == i_req.who);
        q_full   = (r_count == FULL_CNT);
        q_empty  = (r_count == '0);
        head_inc = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
        tail_inc = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;

        n_busy  = r_busy;
        n_owner = r_owner;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        wr_en   = 1'b0;

        o_result.respond = 1'b0;
        o_result.status  = ST_NOTHOLDER;
        o_result.who     = i_req.who;

        if (i_req.req_type == REQ_ACQUIRE) begin
            if (holder) begin
                o_result.respond = 1'b1;
                o_result.status  = ST_HELD;
            end else if (!r_busy) begin
                o_result.respond = 1'b1;
                o_result.status  = ST_GRANTED;
                n_busy  = 1'b1;
                n_owner = i_req.who;
            end else if (q_full) begin
                o_result.respond = 1'b1;
                o_result.status  = ST_FULL;
            end else begin
                o_result.status = ST_QUEUED;
                wr_en   = i_fire;
                n_tail  = tail_inc;
                n_count = r_count + 1'b1;
            end
        end else begin
            if (!holder) begin
                o_result.status = ST_NOTHOLDER;
            end else if (!q_empty) begin
                o_result.respond = 1'b1;
                o_result.status  = ST_HANDOVER;
                o_result.who     = head_who;
                n_owner = head_who;
                n_head  = head_inc;
                n_count = r_count - 1'b1;
            end else begin
                o_result.status = ST_FREED;
                n_busy  = 1'b0;
                n_owner = '0;
            end
        end

        // Hold state when no request is processed
        if (!i_fire) begin
            n_busy  = r_busy;
            n_owner = r_owner;
            n_head  = r_head;
            n_tail  = r_tail;
            n_count = r_count;
        end
    end

    // Advance lock state and the read forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_owner     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_owner     <= n_owner;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_byp_valid <= wr_en && (r_tail == n_head);
        end
        r_byp_data <= i_req.who;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("waiter count above queue depth");

    a_free_no_waiters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_count == '0))
        else $error("waiters present while lock is free");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("head and tail differ on empty queue");

    a_handover_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.status == ST_HANDOVER) |=> r_busy)
        else $error("lock not held after handover");
`endif

endmodule

@@ src/requester_mutex_lock_server_core.sv @@
// Top level of the queued mutex lock server: stream ports, input and result registers.
//
// One request is accepted per clock unless the result stream stalls, and each produces
// exactly one result through the input register, then the result register; the lock
// state closes its loop through the owner compare and the waiter queue pointers, so
// back-to-back requests see each other's effect. The oldest waiter is kept ready at
// the RAM's registered read port, with forwarding for an entry written in the same
// cycle, so a handover needs no separate read. Up to WAIT_DEPTH clients can wait; an
// acquire beyond that is answered with queue full. The waiter RAM needs no clearing
// after reset. Results wait in the output register while the input side keeps
// accepting as long as a stage frees.
module requester_mutex_lock_server_core
    import mlsrv_pkg::*;
#(
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [WHO_W-1:0]    i_s_axis_tdata,   // [7:0] machine_id, [15:8] mailbox
    input  logic                i_s_axis_tuser,   // [0] req_type
    // Result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [WHO_W-1:0]    o_m_axis_tdata,   // [7:0] reply_machine, [15:8] reply_mailbox
    output logic [STAT_W:0]     o_m_axis_tuser    // [0] respond, [3:1] status
);

    logic     r_in_valid;
    t_request r_in_req;
    logic     r_out_valid;
    t_result  r_out;

    logic     advance;
    logic     accept;
    logic     fire;
    t_result  result;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign fire            = r_in_valid && advance;

    mlsrv_engine #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (r_in_req),
        .o_result (result)
    );

    // Input register: capture a transfer, drop it once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in_req.req_type <= i_s_axis_tuser;
            r_in_req.who      <= {i_s_axis_tdata[ID_W-1:0], i_s_axis_tdata[WHO_W-1:ID_W]};
        end
    end

    // Result register: hold until the downstream transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.who[ID_W-1:0], r_out.who[WHO_W-1:ID_W]};
    assign o_m_axis_tuser  = {r_out.status, r_out.respond};

endmodule
